// ===== rtl/cfhd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfhd_pkg: shared types, codes and helpers for the framed header decoder
// Holds the result record, status and kind codes, header layout constants
// and the byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package cfhd_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam int          HDR_CRC_AT = 20;
    localparam int          HDR_LEN    = 24;
    localparam int          IDX_W      = 17;
    localparam int          RQ_DEPTH   = 4;

    localparam logic [7:0]  VERSION_RESET = 8'd1;

    localparam logic        KIND_PAYLOAD = 1'b0;
    localparam logic        KIND_VERDICT = 1'b1;

    localparam logic [2:0]  STATUS_OK          = 3'd0;
    localparam logic [2:0]  STATUS_SHORT_HDR   = 3'd1;
    localparam logic [2:0]  STATUS_BAD_VERSION = 3'd2;
    localparam logic [2:0]  STATUS_SHORT_PAYLD = 3'd3;
    localparam logic [2:0]  STATUS_CRC_ERR     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  hdr_msg_type;
        logic [7:0]  hdr_flags;
        logic [31:0] hdr_seq;
        logic [63:0] hdr_timestamp;
        logic [15:0] hdr_payload_len;
        logic [15:0] hdr_err_code;
    } result_t;

    // Up to two results enter the queue per accepted beat, first one first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Reflected CRC-32, one byte, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfhd_result_queue.sv =====
// ----------------------------------------------------------------------------
// cfhd_result_queue: small result queue between decoder and output stream
// Takes up to two results a cycle, hands out one per beat from registers.
// ----------------------------------------------------------------------------
module cfhd_result_queue #(
    parameter int DEPTH = cfhd_pkg::RQ_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfhd_pkg::push_t   push,
    output logic              room_for_two,
    output logic              out_valid,
    input  logic              out_ready,
    output cfhd_pkg::result_t out_data
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfhd_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] tail_plus1;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[head_reg];
    assign room_for_two = (count_reg <= CW'(DEPTH - 2));
    assign tail_plus1   = ptr_inc(tail_reg);

    always_comb begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + CW'(push.count) - CW'(pop);
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = ptr_inc(tail_plus1);
            default: tail_next = tail_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[tail_plus1] <= push.second;
        end
    end

    // Occupancy never goes past the storage.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("result queue occupancy beyond depth");

    // Results only enter while two slots are free.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> room_for_two)
        else $error("result pushed without room");

    // A push never asks for more than two slots.
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd3)
        else $error("illegal push count");

    // Pop without push drops the occupancy by exactly one.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("occupancy not decremented on pop");

endmodule

// ===== rtl/crc_framed_header_decoder.sv =====
// ----------------------------------------------------------------------------
// crc_framed_header_decoder: CRC-32 checked frame deframer
// Parses a 24-byte little-endian header, forwards payload bytes and reports
// an end-of-frame verdict with the captured header fields.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat on the s_ channel, with s_tlast on
// the final byte, and accepts a beat every cycle. Header, CRC and byte count
// are updated in the accept cycle (one eight-step CRC update per byte), and the
// results land in a four-entry result queue whose head drives the m_ channel;
// results are registered there before they show. Each byte yields no beat
// (header or trailing byte), one payload beat, or, on the final byte, a verdict
// beat after the payload beat of that byte if there is one. The input is held
// off only while fewer than two queue slots are free, so with m_tready high
// the sustained rate is one byte per cycle. The user writes the expected version
// register through cfg_wr_en / cfg_wr_data only while the block is idle; the
// block does not enforce this. The register survives the end-of-frame clear.
// ----------------------------------------------------------------------------
module crc_framed_header_decoder #(
    parameter int RQ_DEPTH = cfhd_pkg::RQ_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,   // expected_version
    // frame bytes in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // [7:0] in_byte
    input  logic         s_tlast,       // frame_last
    // results out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,       // [7:0] payload_byte, [10:8] status,
                                        // [18:11] hdr_msg_type, [26:19] hdr_flags,
                                        // [58:27] hdr_seq, [122:59] hdr_timestamp,
                                        // [138:123] hdr_payload_len,
                                        // [154:139] hdr_err_code, [159:155] zero
    output logic         m_tuser        // kind
);

    localparam int IW = cfhd_pkg::IDX_W;

    logic [7:0]    exp_version_reg;

    logic [IW-1:0] byte_index_reg, byte_index_next;
    logic [31:0]   crc_reg, crc_next;
    logic [7:0]    version_reg, version_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    flags_reg, flags_next;
    logic [31:0]   seq_reg, seq_next;
    logic [63:0]   time_reg, time_next;
    logic [15:0]   length_reg, length_next;
    logic [15:0]   error_reg, error_next;
    logic [31:0]   stored_reg, stored_next;

    // values after this byte is folded in, before any end-of-frame clear
    logic [IW-1:0] idx_cap;
    logic [31:0]   crc_cap;
    logic [7:0]    version_cap, type_cap, flags_cap;
    logic [31:0]   seq_cap, stored_cap;
    logic [63:0]   time_cap;
    logic [15:0]   length_cap, error_cap;

    logic          accept;
    logic          in_hdr;
    logic          is_payload;
    logic [7:0]    crc_data;
    logic [2:0]    status;
    logic [IW:0]   payload_end;
    logic [IW:0]   frame_end;

    cfhd_pkg::result_t payload_res;
    cfhd_pkg::result_t verdict_res;
    cfhd_pkg::result_t head;
    cfhd_pkg::push_t   push;
    logic              room_for_two;

    assign s_tready = room_for_two;
    assign accept   = s_tvalid && s_tready;

    // ---- configuration register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg <= cfhd_pkg::VERSION_RESET;
        end else if (cfg_wr_en) begin
            exp_version_reg <= cfg_wr_data;
        end
    end

    // ---- per-byte decode ----
    always_comb begin
        in_hdr      = (byte_index_reg < IW'(cfhd_pkg::HDR_LEN));
        payload_end = (IW+1)'(cfhd_pkg::HDR_LEN) + (IW+1)'(length_reg);
        is_payload  = !in_hdr && ({1'b0, byte_index_reg} < payload_end);

        version_cap = version_reg;
        type_cap    = type_reg;
        flags_cap   = flags_reg;
        seq_cap     = seq_reg;
        time_cap    = time_reg;
        length_cap  = length_reg;
        error_cap   = error_reg;
        stored_cap  = stored_reg;

        // capture header bytes into their lanes; pad byte is dropped
        if (in_hdr) begin
            case (byte_index_reg[4:0]) inside
                5'd0:           version_cap = s_tdata;
                5'd1:           type_cap    = s_tdata;
                5'd2:           flags_cap   = s_tdata;
                [5'd4:5'd7]:    seq_cap[byte_index_reg[1:0]*8 +: 8] = s_tdata;
                [5'd8:5'd15]:   time_cap[byte_index_reg[2:0]*8 +: 8] = s_tdata;
                [5'd16:5'd17]:  length_cap[byte_index_reg[0]*8 +: 8] = s_tdata;
                [5'd18:5'd19]:  error_cap[byte_index_reg[0]*8 +: 8] = s_tdata;
                [5'd20:5'd23]:  stored_cap[byte_index_reg[1:0]*8 +: 8] = s_tdata;
                default:        ;
            endcase
        end

        // stored CRC bytes enter the CRC as zero
        crc_data = (in_hdr && byte_index_reg >= IW'(cfhd_pkg::HDR_CRC_AT)) ? 8'd0 : s_tdata;
        crc_cap  = (in_hdr || is_payload) ? cfhd_pkg::crc_byte(crc_reg, crc_data) : crc_reg;

        // saturate the byte count
        idx_cap = (byte_index_reg == '1) ? byte_index_reg : byte_index_reg + IW'(1);

        // verdict, checked in priority order
        frame_end = (IW+1)'(cfhd_pkg::HDR_LEN) + (IW+1)'(length_cap);
        if (idx_cap < IW'(cfhd_pkg::HDR_LEN)) begin
            status = cfhd_pkg::STATUS_SHORT_HDR;
        end else if (version_cap != exp_version_reg) begin
            status = cfhd_pkg::STATUS_BAD_VERSION;
        end else if ({1'b0, idx_cap} < frame_end) begin
            status = cfhd_pkg::STATUS_SHORT_PAYLD;
        end else if (~crc_cap != stored_cap) begin
            status = cfhd_pkg::STATUS_CRC_ERR;
        end else begin
            status = cfhd_pkg::STATUS_OK;
        end
    end

    // ---- result records ----
    always_comb begin
        payload_res              = '0;
        payload_res.kind         = cfhd_pkg::KIND_PAYLOAD;
        payload_res.payload_byte = s_tdata;

        verdict_res                 = '0;
        verdict_res.kind            = cfhd_pkg::KIND_VERDICT;
        verdict_res.status          = status;
        verdict_res.hdr_msg_type    = type_cap;
        verdict_res.hdr_flags       = flags_cap;
        verdict_res.hdr_seq         = seq_cap;
        verdict_res.hdr_timestamp   = time_cap;
        verdict_res.hdr_payload_len = length_cap;
        verdict_res.hdr_err_code    = error_cap;

        // payload beat goes first when the final byte also carries payload
        push.first  = is_payload ? payload_res : verdict_res;
        push.second = verdict_res;
        push.count  = accept ? (2'(is_payload) + 2'(s_tlast)) : 2'd0;
    end

    // ---- frame state: advance on accept, clear after the final byte ----
    always_comb begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        flags_next      = flags_reg;
        seq_next        = seq_reg;
        time_next       = time_reg;
        length_next     = length_reg;
        error_next      = error_reg;
        stored_next     = stored_reg;
        if (accept) begin
            if (s_tlast) begin
                byte_index_next = '0;
                crc_next        = cfhd_pkg::CRC_INIT;
                version_next    = '0;
                type_next       = '0;
                flags_next      = '0;
                seq_next        = '0;
                time_next       = '0;
                length_next     = '0;
                error_next      = '0;
                stored_next     = '0;
            end else begin
                byte_index_next = idx_cap;
                crc_next        = crc_cap;
                version_next    = version_cap;
                type_next       = type_cap;
                flags_next      = flags_cap;
                seq_next        = seq_cap;
                time_next       = time_cap;
                length_next     = length_cap;
                error_next      = error_cap;
                stored_next     = stored_cap;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            crc_reg        <= cfhd_pkg::CRC_INIT;
            version_reg    <= '0;
            type_reg       <= '0;
            flags_reg      <= '0;
            seq_reg        <= '0;
            time_reg       <= '0;
            length_reg     <= '0;
            error_reg      <= '0;
            stored_reg     <= '0;
        end else begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            version_reg    <= version_next;
            type_reg       <= type_next;
            flags_reg      <= flags_next;
            seq_reg        <= seq_next;
            time_reg       <= time_next;
            length_reg     <= length_next;
            error_reg      <= error_next;
            stored_reg     <= stored_next;
        end
    end

    // ---- result queue and output stream ----
    cfhd_result_queue #(
        .DEPTH (RQ_DEPTH)
    ) u_result_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (head)
    );

    assign m_tuser = head.kind;
    assign m_tdata = {5'd0, head.hdr_err_code, head.hdr_payload_len, head.hdr_timestamp,
                      head.hdr_seq, head.hdr_flags, head.hdr_msg_type, head.status,
                      head.payload_byte};

endmodule

// ===== verif/crc_framed_header_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_framed_header_decoder_tb: self-checking bench for the framed decoder
// Streams whole frames into the decoder. Most are well-formed, with a correct
// CRC and random header and payload content. The rest are broken: short
// headers, wrong versions, short payloads, bad CRCs and trailing bytes. A
// scoreboard predicts every payload beat and every verdict beat and compares
// them field by field.
// ----------------------------------------------------------------------------
module crc_framed_header_decoder_tb;
    import cfhd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any accepted beat
    localparam int RX_HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 20;     // settle time after the last result
    localparam int IDLE_CYCLES    = 8;      // settle time before a register write
    localparam int PHASE_BYTES    = 400;    // bytes per random phase

    // header fill styles for the frame builder
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the decoder state as bytes are accepted and holds the
    // result beats still owed by the block.
    // ------------------------------------------------------------------------
    class frame_checker;
        bit [IDX_W-1:0] byte_count;
        bit [31:0]      crc_reg;
        bit [7:0]       ver_cap;
        bit [7:0]       type_cap;
        bit [7:0]       flags_cap;
        bit [31:0]      seq_cap;
        bit [63:0]      ts_cap;
        bit [15:0]      len_cap;
        bit [15:0]      err_cap;
        bit [31:0]      crc_cap;
        bit [7:0]       want_version;
        result_t        expected_beats[$];
        int             mismatches;

        function new();
            want_version = VERSION_RESET;
            mismatches   = 0;
            clear_frame();
        endfunction

        // Reflected CRC-32 update over one byte, LSB first.
        static function bit [31:0] crc_next(bit [31:0] c, bit [7:0] b);
            bit [31:0] r;
            r = c ^ {24'd0, b};
            repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
            return r;
        endfunction

        function void clear_frame();
            byte_count = '0;
            crc_reg    = CRC_INIT;
            ver_cap    = '0;
            type_cap   = '0;
            flags_cap  = '0;
            seq_cap    = '0;
            ts_cap     = '0;
            len_cap    = '0;
            err_cap    = '0;
            crc_cap    = '0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Advance the state by one accepted byte and queue the beats it owes.
        function void note_byte(bit [7:0] b, bit is_last);
            int      pos;
            result_t r;
            pos = int'(byte_count);
            if (pos < HDR_LEN) begin
                if (pos == 0) ver_cap = b;
                else if (pos == 1) type_cap = b;
                else if (pos == 2) flags_cap = b;
                else if (pos >= 4 && pos < 8) seq_cap[(pos - 4) * 8 +: 8] = b;
                else if (pos >= 8 && pos < 16) ts_cap[(pos - 8) * 8 +: 8] = b;
                else if (pos >= 16 && pos < 18) len_cap[(pos - 16) * 8 +: 8] = b;
                else if (pos >= 18 && pos < 20) err_cap[(pos - 18) * 8 +: 8] = b;
                else if (pos >= HDR_CRC_AT) crc_cap[(pos - HDR_CRC_AT) * 8 +: 8] = b;
                // stored CRC bytes enter the checksum as zero
                crc_reg = crc_next(crc_reg, (pos >= HDR_CRC_AT) ? 8'd0 : b);
            end else if (pos < HDR_LEN + int'(len_cap)) begin
                crc_reg        = crc_next(crc_reg, b);
                r              = '0;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                expected_beats.push_back(r);
            end
            if (byte_count != '1) byte_count = byte_count + IDX_W'(1);

            if (is_last) begin
                r        = '0;
                r.kind   = KIND_VERDICT;
                if (int'(byte_count) < HDR_LEN) r.status = STATUS_SHORT_HDR;
                else if (ver_cap != want_version) r.status = STATUS_BAD_VERSION;
                else if (int'(byte_count) < HDR_LEN + int'(len_cap))
                    r.status = STATUS_SHORT_PAYLD;
                else if (~crc_reg != crc_cap) r.status = STATUS_CRC_ERR;
                else r.status = STATUS_OK;
                r.hdr_msg_type    = type_cap;
                r.hdr_flags       = flags_cap;
                r.hdr_seq         = seq_cap;
                r.hdr_timestamp   = ts_cap;
                r.hdr_payload_len = len_cap;
                r.hdr_err_code    = err_cap;
                expected_beats.push_back(r);
                clear_frame();
            end
        endfunction

        function void flag_if(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // Compare one accepted result beat with the oldest one owed.
        function void check_beat(logic kind, logic [159:0] data);
            result_t want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with none owed: kind %0b data %0h", kind, data);
                return;
            end
            want = expected_beats.pop_front();
            flag_if("kind",            64'(want.kind),            64'(kind));
            flag_if("payload_byte",    64'(want.payload_byte),    64'(data[7:0]));
            flag_if("status",          64'(want.status),          64'(data[10:8]));
            flag_if("hdr_msg_type",    64'(want.hdr_msg_type),    64'(data[18:11]));
            flag_if("hdr_flags",       64'(want.hdr_flags),       64'(data[26:19]));
            flag_if("hdr_seq",         64'(want.hdr_seq),         64'(data[58:27]));
            flag_if("hdr_timestamp",   want.hdr_timestamp,        data[122:59]);
            flag_if("hdr_payload_len", 64'(want.hdr_payload_len), 64'(data[138:123]));
            flag_if("hdr_err_code",    64'(want.hdr_err_code),    64'(data[154:139]));
            flag_if("tdata padding",   64'd0,                     64'(data[159:155]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [7:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         m_tuser;

    crc_framed_header_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    frame_checker chk;
    bit [7:0]     frame_bytes[$];   // frame under construction / being sent
    bit [7:0]     cur_version;      // what the version register holds now
    bit           tx_calm;          // sender offers back to back
    bit           rx_calm;          // receiver never stalls
    bit           rx_hold_req;      // ask the receiver for one long hold-off
    int           idle_cycles;

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Note the input beat
    // before checking, though a byte's results never show in its own cycle.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) chk.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) chk.check_beat(m_tuser, m_tdata);
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
            $display("crc_framed_header_decoder_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drive m_tready at the falling edge. Mostly ready, with short
    // and occasional long stalls, none at all while rx_calm is set, and one
    // long hold-off on request so the result queue backs up into s_tready.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int r;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                stall_left  = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (!rx_calm) begin
                    r = $urandom_range(0, 99);
                    if (r < 12) stall_left = $urandom_range(1, 3);
                    else if (r < 14) stall_left = $urandom_range(15, 60);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Gap before the next beat: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [7:0] fill_byte(int fill);
        if (fill == FILL_ZERO) return 8'h00;
        if (fill == FILL_ONES) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Build a frame in frame_bytes: header, pay_n payload bytes, stored CRC
    // over the header and the first min(pay_n, plen) payload bytes. Corrupt the
    // CRC when good_crc is clear; keep only the first keep bytes if keep > 0.
    task automatic build_frame(input bit [7:0] ver, input int plen, input int pay_n,
                               input bit good_crc, input int fill, input int keep);
        bit [15:0] len_bits;
        bit [31:0] c;
        int        n_crc;
        len_bits = 16'(plen);
        frame_bytes.delete();
        frame_bytes.push_back(ver);
        for (int i = 1; i < 16; i++) frame_bytes.push_back(fill_byte(fill));
        frame_bytes.push_back(len_bits[7:0]);
        frame_bytes.push_back(len_bits[15:8]);
        frame_bytes.push_back(fill_byte(fill));
        frame_bytes.push_back(fill_byte(fill));
        repeat (4) frame_bytes.push_back(8'h00);    // CRC slot, read as zero
        for (int i = 0; i < pay_n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));

        n_crc = HDR_LEN + ((pay_n < plen) ? pay_n : plen);
        c     = CRC_INIT;
        for (int i = 0; i < n_crc; i++) c = frame_checker::crc_next(c, frame_bytes[i]);
        c = ~c;
        if (!good_crc) c = c ^ ($urandom() | 32'd1);
        for (int i = 0; i < 4; i++) frame_bytes[HDR_CRC_AT + i] = c[i * 8 +: 8];

        if (keep > 0)
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endtask

    // Offer one beat and hold it until taken. Enter and leave at a falling
    // edge; s_tvalid stays high for a following beat with no gap.
    task automatic send_beat(input bit [7:0] b, input bit is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = is_last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drop valid and wait until every owed result has come out, then let the
    // pipeline settle.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (chk.pending() != 0) @(negedge aclk);
        repeat (IDLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_version(input bit [7:0] v);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en        = 1'b0;
        cur_version      = v;
        chk.want_version = v;
    endtask

    // Random frames until n_bytes have gone in. About 70 percent are
    // well-formed; the rest cover each way a frame can fail.
    task automatic run_random(input int n_bytes);
        int       sent;
        int       r;
        int       plen;
        int       pay_n;
        int       keep;
        bit [7:0] ver;
        bit       good;
        sent = 0;
        while (sent < n_bytes) begin
            r     = $urandom_range(0, 99);
            ver   = cur_version;
            good  = 1'b1;
            keep  = 0;
            plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                : $urandom_range(0, 24);
            pay_n = plen;
            if (r < 8) begin
                good = 1'b0;
            end else if (r < 13) begin
                ver = cur_version ^ 8'($urandom_range(1, 255));
            end else if (r < 18) begin
                plen  = $urandom_range(1, 65535);
                pay_n = $urandom_range(0, (plen > 30) ? 30 : plen - 1);
            end else if (r < 23) begin
                pay_n = plen + $urandom_range(1, 10);
            end else if (r < 30) begin
                ver  = 8'($urandom_range(0, 255));
                keep = $urandom_range(1, HDR_LEN - 1);
            end
            build_frame(ver, plen, pay_n, good, FILL_RANDOM, keep);
            send_frame();
            sent += frame_bytes.size();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [7:0] phase_version[4];

        chk         = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tlast     = 1'b0;
        cur_version = VERSION_RESET;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        rx_hold_req = 1'b0;
        idle_cycles = 0;

        // hold reset, release at a falling edge
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed frames at the reset version.
        // A lone final byte and a 23-byte header with all-ones fields: short header.
        build_frame(cur_version, 0, 0, 1'b1, FILL_RANDOM, 1);
        send_frame();
        build_frame(cur_version, 16'hFFFF, 0, 1'b1, FILL_ONES, HDR_LEN - 1);
        send_frame();
        // Header only, all zero fields, good CRC: ok.
        build_frame(cur_version, 0, 0, 1'b1, FILL_ZERO, 0);
        send_frame();
        // All-ones header fields with a short payload: ok.
        build_frame(cur_version, 3, 3, 1'b1, FILL_ONES, 0);
        send_frame();
        // Wrong version: payload still passes through, then bad version.
        build_frame(cur_version + 8'd1, 4, 4, 1'b1, FILL_RANDOM, 0);
        send_frame();
        // Payload cut short, then a checksum error.
        build_frame(cur_version, 10, 5, 1'b1, FILL_RANDOM, 0);
        send_frame();
        build_frame(cur_version, 2, 2, 1'b0, FILL_RANDOM, 0);
        send_frame();
        // Bytes past the declared length are ignored: ok.
        build_frame(cur_version, 2, 6, 1'b1, FILL_RANDOM, 0);
        send_frame();
        // Largest declared length with only a few bytes sent: short payload.
        build_frame(cur_version, 65535, 3, 1'b1, FILL_ONES, 0);
        send_frame();

        // Back-pressure: hold the receiver off while the sender streams a
        // frame with no gaps, so the result queue fills and s_tready drops.
        wait_idle();
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
        build_frame(cur_version, 40, 40, 1'b1, FILL_RANDOM, 0);
        send_frame();
        wait_idle();
        tx_calm = 1'b0;

        // Random phases, one version setting each, extremes included.
        phase_version[0] = 8'd0;
        phase_version[1] = 8'hFF;
        phase_version[2] = 8'($urandom_range(2, 254));
        phase_version[3] = VERSION_RESET;
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_version(phase_version[p]);
            // vary the idling: calm sender, calm receiver, or both random
            tx_calm = (p == 1);
            rx_calm = (p == 2);
            run_random(PHASE_BYTES);
        end

        // Drain: wait for every owed beat, then watch for stray ones.
        s_tvalid = 1'b0;
        while (chk.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("crc_framed_header_decoder_tb OK");
        end else begin
            $display("crc_framed_header_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
